// File: design/brmg_pkg.sv
// shared types, constants and sequencing helpers for the bilinear root mapper
package brmg_pkg;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int MUL_DIGIT     = 16;

  localparam logic CFG_GAIN_REAL = 1'b0;
  localparam logic CFG_GAIN_IMAG = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_MEND,
    ST_DSTART,
    ST_DWAIT,
    ST_CLIP,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    SP_AA,
    SP_BB,
    SP_TT,
    SP_MR,
    SP_MI,
    SP_FR,
    SP_FI,
    SP_GR1,
    SP_GR2,
    SP_GI1,
    SP_GI2
  } step_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  // state that carries out a given step
  function automatic state_t step_state(step_t s, logic div_fac);
    state_t r;
    case (s)
      SP_AA, SP_BB, SP_TT, SP_GR1, SP_GR2, SP_GI1, SP_GI2: r = ST_MUL;
      SP_MR, SP_MI: r = ST_DSTART;
      SP_FR, SP_FI: r = div_fac ? ST_DSTART : ST_CLIP;
      default: r = ST_OUT;
    endcase
    return r;
  endfunction

endpackage

// File: design/bilinear_root_map_gain.sv
// top level: bilinear root mapping with gain factor and running complex gain
//
// channel  | direction | contents
// s_*      | in        | tdata: root_real, root_imag; tuser: is_pole, first_root
// m_*      | out       | tdata: mapped_real/imag, factor_real/imag, gain_real/imag;
//          |           | tuser: mapped_finite, saturated
// cfg_*    | in        | write enable, index, data for initial_gain_real/imag
//
// one transaction in flight; a zero runs two divisions and a pole four, each with its clip,
// on the bit-serial divider, and both run seven products on the 16-bit-digit multiplier.
// the root at minus i skips the mapping.
// reset is synchronous; it clears the sequencer, running gain and output valid.
// a stalled result holds in the output register; the next root is taken in but waits for it
// before it can finish.
module bilinear_root_map_gain #(
  parameter int WORD_BITS = brmg_pkg::DEF_WORD_BITS,
  parameter int FRAC_BITS = brmg_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // root_real, root_imag
  input  logic [((2*WORD_BITS+7)/8)*8-1:0] s_tdata,
  // is_pole, first_root
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // mapped_real, mapped_imag, factor_real, factor_imag, gain_real, gain_imag
  output logic [((6*WORD_BITS+7)/8)*8-1:0] m_tdata,
  // mapped_finite, saturated
  output logic [1:0]                  m_tuser,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [WORD_BITS-1:0]        cfg_data
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int ODW  = ((6*W+7)/8)*8;
  localparam int OW   = ((W > F + 1) ? W : F + 1) + 1;
  localparam int PW   = 2 * OW;
  localparam int AW   = PW + 2;
  localparam int NW   = ((PW + 1 > 2*F + 1) ? PW + 1 : 2*F + 1) + 1;
  localparam int XW   = NW + 2*F + 2;
  localparam int DENW = PW + 1;
  localparam int RW   = ((XW > DENW + W + 1) ? XW : DENW + W + 1) + 1;
  localparam int DG   = brmg_pkg::MUL_DIGIT;
  localparam int MS   = (OW + DG - 1) / DG;
  localparam int BP   = MS * DG;
  localparam int MIW  = (MS > 1) ? $clog2(MS) : 1;

  brmg_pkg::state_t state, state_next;
  brmg_pkg::step_t  step;

  logic [W-1:0] cfg_gr, cfg_gi;
  logic [W-1:0] cr, ci;
  logic [W-1:0] a, b;
  logic         pole;
  logic [PW-1:0] aa, bb, tt;
  logic [W-1:0] mr, mi, fr, fi, gr, gi;
  logic         sat;
  logic [AW-1:0] gacc;
  logic [PW-1:0] macc;
  logic [MIW-1:0] mcnt;

  logic [W-1:0] o_mr, o_mi, o_fr, o_fi, o_gr, o_gi;
  logic         o_fin, o_sat;

  // derived root quantities
  logic signed [OW:0] a_x, b_x, bpo;
  logic [OW-1:0] ma, mb, mt;
  logic          tneg, a_pos, a_neg, special, div_fac;

  assign a_x     = OW'(0) + {{(OW+1-W){a[W-1]}}, a};
  assign b_x     = {{(OW+1-W){b[W-1]}}, b};
  assign bpo     = b_x + ((OW+1)'(1) << F);
  assign tneg    = bpo[OW];
  assign ma      = a_x[OW] ? OW'(-a_x) : OW'(a_x);
  assign mb      = b_x[OW] ? OW'(-b_x) : OW'(b_x);
  assign mt      = tneg ? OW'(-bpo) : OW'(bpo);
  assign a_neg   = a[W-1];
  assign a_pos   = !a[W-1] && (a != '0);
  assign special = (a == '0) && (bpo == '0);
  assign div_fac = pole && !special;

  // magnitudes for the gain products
  logic [OW-1:0] m_cr, m_ci, m_fr, m_fi;
  assign m_cr = cr[W-1] ? OW'(-{{(OW-W){1'b1}}, cr}) : OW'(cr);
  assign m_ci = ci[W-1] ? OW'(-{{(OW-W){1'b1}}, ci}) : OW'(ci);
  assign m_fr = fr[W-1] ? OW'(-{{(OW-W){1'b1}}, fr}) : OW'(fr);
  assign m_fi = fi[W-1] ? OW'(-{{(OW-W){1'b1}}, fi}) : OW'(fi);

  // shared digit multiplier
  logic [OW-1:0]    mul_a, mul_b;
  logic             pneg;
  logic [BP-1:0]    b_pad;
  logic [DG-1:0]    digit;
  logic [OW+DG-1:0] prod;
  logic [AW-1:0]    term;

  always_comb begin
    mul_a = ma;
    mul_b = ma;
    pneg  = 1'b0;
    case (step)
      brmg_pkg::SP_AA: begin mul_a = ma; mul_b = ma; end
      brmg_pkg::SP_BB: begin mul_a = mb; mul_b = mb; end
      brmg_pkg::SP_TT: begin mul_a = mt; mul_b = mt; end
      brmg_pkg::SP_GR1: begin mul_a = m_cr; mul_b = m_fr; pneg = cr[W-1] ^ fr[W-1]; end
      brmg_pkg::SP_GR2: begin mul_a = m_ci; mul_b = m_fi; pneg = !(ci[W-1] ^ fi[W-1]); end
      brmg_pkg::SP_GI1: begin mul_a = m_cr; mul_b = m_fi; pneg = cr[W-1] ^ fi[W-1]; end
      brmg_pkg::SP_GI2: begin mul_a = m_ci; mul_b = m_fr; pneg = ci[W-1] ^ fr[W-1]; end
      default: ;
    endcase
  end

  assign b_pad = BP'(mul_b);
  assign digit = b_pad[mcnt*DG +: DG];
  assign prod  = (OW+DG)'(mul_a) * (OW+DG)'(digit);
  assign term  = pneg ? AW'(-AW'(macc)) : AW'(macc);

  // divider operands
  logic [NW-1:0] q_one, p_sum, num_mr;
  logic          mr_neg;
  logic [RW-1:0] div_num, div_den, div_mag;
  brmg_pkg::div_ctl_t div_ci, div_co;

  assign q_one  = NW'(1) << (2*F);
  assign p_sum  = NW'(aa) + NW'(bb);
  assign mr_neg = p_sum > q_one;
  assign num_mr = mr_neg ? p_sum - q_one : q_one - p_sum;
  assign div_den = RW'(NW'(aa) + NW'(tt));

  always_comb begin
    case (step)
      brmg_pkg::SP_MR: div_num = RW'(num_mr) << (F + 1);
      brmg_pkg::SP_MI: div_num = RW'(ma) << (2*F + 2);
      brmg_pkg::SP_FR: div_num = RW'(ma) << (2*F + 1);
      brmg_pkg::SP_FI: div_num = RW'(mt) << (2*F + 1);
      default:         div_num = '0;
    endcase
  end

  brmg_div #(
    .WORD_BITS(W),
    .RW       (RW)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (div_ci),
    .num    (div_num),
    .den    (div_den),
    .ctl_out(div_co),
    .mag    (div_mag)
  );

  // shared saturation unit
  logic [AW-1:0] gmag, grnd;
  logic          cl_neg, cl_sat;
  logic [RW-1:0] cl_mag, cl_lim, cl_use;
  logic [W-1:0]  cl_val;

  assign gmag = gacc[AW-1] ? AW'(-gacc) : gacc;
  assign grnd = (gmag + (AW'(1) << (F - 1))) >> F;

  always_comb begin
    cl_neg = 1'b0;
    cl_mag = '0;
    case (step)
      brmg_pkg::SP_MR: begin cl_neg = mr_neg; cl_mag = div_mag; end
      brmg_pkg::SP_MI: begin cl_neg = a_neg; cl_mag = div_mag; end
      brmg_pkg::SP_FR: begin
        if (div_fac) begin
          cl_neg = a_pos; cl_mag = div_mag;
        end else if (!special) begin
          cl_neg = a_pos; cl_mag = RW'(ma);
        end
      end
      brmg_pkg::SP_FI: begin
        if (div_fac) begin
          cl_neg = tneg; cl_mag = div_mag;
        end else if (special) begin
          cl_neg = pole;
          cl_mag = pole ? (RW'(1) << (F - 1)) : (RW'(1) << (F + 1));
        end else begin
          cl_neg = !tneg && (mt != '0); cl_mag = RW'(mt);
        end
      end
      brmg_pkg::SP_GR2, brmg_pkg::SP_GI2: begin
        cl_neg = gacc[AW-1]; cl_mag = RW'(grnd);
      end
      default: ;
    endcase
  end

  assign cl_lim = (RW'(1) << (W - 1)) - RW'(!cl_neg);
  assign cl_sat = cl_mag > cl_lim;
  assign cl_use = cl_sat ? cl_lim : cl_mag;
  assign cl_val = cl_neg ? W'(~cl_use[W-1:0] + W'(1)) : cl_use[W-1:0];

  // sequencer
  logic accept, out_load, grp_end;
  brmg_pkg::step_t step_inc;

  assign step_inc = brmg_pkg::step_t'(step + 4'd1);
  assign grp_end  = (step == brmg_pkg::SP_GR2) || (step == brmg_pkg::SP_GI2);

  always_comb begin
    state_next = state;
    case (state)
      brmg_pkg::ST_IDLE:   if (s_tvalid) state_next = brmg_pkg::ST_SETUP;
      brmg_pkg::ST_SETUP:
        state_next = brmg_pkg::step_state(special ? brmg_pkg::SP_FR : brmg_pkg::SP_AA,
                                          div_fac);
      brmg_pkg::ST_MUL:    if (mcnt == '0) state_next = brmg_pkg::ST_MEND;
      brmg_pkg::ST_MEND:
        state_next = grp_end ? brmg_pkg::ST_CLIP : brmg_pkg::step_state(step_inc, div_fac);
      brmg_pkg::ST_DSTART: state_next = brmg_pkg::ST_DWAIT;
      brmg_pkg::ST_DWAIT:  if (div_co.done) state_next = brmg_pkg::ST_CLIP;
      brmg_pkg::ST_CLIP:
        state_next = (step == brmg_pkg::SP_GI2) ? brmg_pkg::ST_OUT
                                                : brmg_pkg::step_state(step_inc, div_fac);
      brmg_pkg::ST_OUT:    if (!m_tvalid || m_tready) state_next = brmg_pkg::ST_IDLE;
      default:             state_next = brmg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == brmg_pkg::ST_IDLE);
    div_ci.start = (state == brmg_pkg::ST_DSTART);
    div_ci.done  = 1'b0;
    out_load     = (state == brmg_pkg::ST_OUT) && (!m_tvalid || m_tready);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= brmg_pkg::ST_IDLE;
      step     <= brmg_pkg::SP_AA;
      m_tvalid <= 1'b0;
      cfg_gr   <= W'(1) << F;
      cfg_gi   <= '0;
      cr       <= '0;
      ci       <= '0;
      mcnt     <= MIW'(MS - 1);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == brmg_pkg::CFG_GAIN_REAL) cfg_gr <= cfg_data;
        if (cfg_index == brmg_pkg::CFG_GAIN_IMAG) cfg_gi <= cfg_data;
      end
      if (accept) begin
        step <= brmg_pkg::SP_AA;
        if (s_tuser[1]) begin
          cr <= cfg_gr;
          ci <= cfg_gi;
        end
      end
      if (state == brmg_pkg::ST_SETUP && special) step <= brmg_pkg::SP_FR;
      if ((state == brmg_pkg::ST_MEND && !grp_end) ||
          (state == brmg_pkg::ST_CLIP && step != brmg_pkg::SP_GI2)) begin
        step <= step_inc;
      end
      if (state == brmg_pkg::ST_MUL) mcnt <= mcnt - MIW'(1);
      else                           mcnt <= MIW'(MS - 1);
      if (out_load) begin
        m_tvalid <= 1'b1;
        cr       <= gr;
        ci       <= gi;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      a    <= s_tdata[W-1:0];
      b    <= s_tdata[2*W-1:W];
      pole <= s_tuser[0];
      sat  <= 1'b0;
      mr   <= '0;
      mi   <= '0;
    end
    if (state == brmg_pkg::ST_MUL) begin
      macc <= ((mcnt == MIW'(MS - 1)) ? PW'(0) : (macc << DG)) + PW'(prod);
    end
    if (state == brmg_pkg::ST_MEND) begin
      case (step)
        brmg_pkg::SP_AA: aa <= macc;
        brmg_pkg::SP_BB: bb <= macc;
        brmg_pkg::SP_TT: tt <= macc;
        brmg_pkg::SP_GR1, brmg_pkg::SP_GI1: gacc <= term;
        brmg_pkg::SP_GR2, brmg_pkg::SP_GI2: gacc <= gacc + term;
        default: ;
      endcase
    end
    if (state == brmg_pkg::ST_CLIP) begin
      sat <= sat | cl_sat;
      case (step)
        brmg_pkg::SP_MR:  mr <= cl_val;
        brmg_pkg::SP_MI:  mi <= cl_val;
        brmg_pkg::SP_FR:  fr <= cl_val;
        brmg_pkg::SP_FI:  fi <= cl_val;
        brmg_pkg::SP_GR2: gr <= cl_val;
        brmg_pkg::SP_GI2: gi <= cl_val;
        default: ;
      endcase
    end
    if (out_load) begin
      o_mr  <= mr;
      o_mi  <= mi;
      o_fr  <= fr;
      o_fi  <= fi;
      o_gr  <= gr;
      o_gi  <= gi;
      o_fin <= !special;
      o_sat <= sat;
    end
  end

  assign m_tdata = ODW'({o_gi, o_gr, o_fi, o_fr, o_mi, o_mr});
  assign m_tuser = {o_sat, o_fin};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again while busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    state == brmg_pkg::ST_OUT && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("finished result not presented");

  a_infinite_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[2*W-1:0] == '0)
    else $error("root at infinity with nonzero image");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_co.done |-> state == brmg_pkg::ST_DWAIT)
    else $error("divider finished outside its wait state");

endmodule

// File: design/brmg_div.sv
// iterative restoring divider, one quotient bit per cycle, rounded, magnitude clamped on overflow
module brmg_div #(
  parameter int WORD_BITS = brmg_pkg::DEF_WORD_BITS,
  parameter int RW        = 3 * brmg_pkg::DEF_WORD_BITS + 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  brmg_pkg::div_ctl_t       ctl_in,
  input  logic [RW-1:0]            num,
  input  logic [RW-1:0]            den,
  output brmg_pkg::div_ctl_t       ctl_out,
  output logic [RW-1:0]            mag
);

  localparam int QW  = WORD_BITS + 1;
  localparam int DCW = $clog2(QW);

  logic [RW-1:0]  rem;
  logic [RW-1:0]  dsh;
  logic [QW-1:0]  quo;
  logic [DCW-1:0] cnt;
  logic           busy;
  logic           ovf;
  logic           done;
  logic [QW:0]    rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      rem <= num;
      dsh <= den << WORD_BITS;
      ovf <= num >= (den << (WORD_BITS + 1));
      quo <= '0;
      cnt <= DCW'(WORD_BITS);
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        quo <= {quo[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - DCW'(1);
    end
  end

  assign rnd = ((QW+1)'(quo) + (QW+1)'(1)) >> 1;
  assign mag = ovf ? (RW'(1) << WORD_BITS) : RW'(rnd);

  always_comb begin
    ctl_out.start = 1'b0;
    ctl_out.done  = done;
  end

endmodule

// File: test/brmg_checker.sv
// checker for the bilinear root mapper: predicts each result and compares it
`timescale 1ns / 100ps

module brmg_checker #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tready,
  input  logic [63:0]   s_tdata,
  input  logic [1:0]    s_tuser,
  input  logic          m_tvalid,
  input  logic          m_tready,
  input  logic [191:0]  m_tdata,
  input  logic [1:0]    m_tuser,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [W-1:0]  cfg_data,
  output int            errors,
  output int            pending,
  output int            checked,
  output int            nonfinite_seen,
  output int            sat_seen
);

  typedef struct {
    logic [W-1:0] mapped_re;
    logic [W-1:0] mapped_im;
    logic         finite;
    logic [W-1:0] factor_re;
    logic [W-1:0] factor_im;
    logic [W-1:0] gain_re;
    logic [W-1:0] gain_im;
    logic         sat;
  } root_result_t;

  root_result_t expected_roots[$];
  logic [W-1:0] start_gain_re, start_gain_im;
  logic [W-1:0] acc_gain_re, acc_gain_im;
  logic         clip_hit;
  int           err_cnt, chk_cnt, inf_cnt, sat_cnt;

  assign errors         = err_cnt;
  assign pending        = expected_roots.size();
  assign checked        = chk_cnt;
  assign nonfinite_seen = inf_cnt;
  assign sat_seen       = sat_cnt;

  function automatic logic [W-1:0] clip_word(bit neg, logic [255:0] m);
    logic [255:0] mx;
    logic [255:0] n;
    mx = (256'd1 << (W-1)) - 1;
    if (!neg) begin
      if (m > mx) begin
        clip_hit = 1'b1;
        return mx[W-1:0];
      end
      return m[W-1:0];
    end
    if (m > mx + 1) begin
      clip_hit = 1'b1;
      m = mx + 1;
    end
    n = 256'd0 - m;
    return n[W-1:0];
  endfunction

  // rounded num * 2^sh / den, ties away from zero
  function automatic logic [W-1:0] div_round(logic [255:0] num, logic [255:0] den, int sh,
                                             bit neg);
    logic [255:0] qf;
    if (den == 0) return clip_word(neg, 256'd1 << 64);
    qf = (num << (sh + 1)) / den;
    if (qf >= (256'd1 << 64)) return clip_word(neg, 256'd1 << 64);
    return clip_word(neg, (qf >> 1) + (qf & 256'd1));
  endfunction

  function automatic logic [W-1:0] gain_round(logic signed [255:0] t);
    bit           neg;
    logic [255:0] mag;
    neg = t < 0;
    mag = neg ? -t : t;
    return clip_word(neg, (mag + (256'd1 << (F-1))) >> F);
  endfunction

  function automatic root_result_t map_root(logic [W-1:0] re, logic [W-1:0] im,
                                            bit pole, bit first);
    root_result_t        r;
    logic signed [255:0] as, bs, ts, p, q, cr, ci, fr, fi;
    logic [255:0]        ma, mt, den;
    bit                  tneg;
    clip_hit = 1'b0;
    if (first) begin
      acc_gain_re = start_gain_re;
      acc_gain_im = start_gain_im;
    end
    as = $signed(re);
    bs = $signed(im);
    r.mapped_re = '0;
    r.mapped_im = '0;
    r.finite = 1'b1;
    if (as == 0 && bs == -(256'sd1 <<< F)) begin
      r.finite = 1'b0;
      r.factor_re = '0;
      r.factor_im = pole ? clip_word(1'b1, 256'd1 << (F-1)) : clip_word(1'b0, 256'd1 << (F+1));
    end else begin
      ma = as < 0 ? -as : as;
      ts = bs + (256'sd1 <<< F);
      tneg = ts < 0;
      mt = tneg ? -ts : ts;
      den = mt * mt + ma * ma;
      p = as * as + bs * bs;
      q = 256'sd1 <<< (2*F);
      if (q >= p) r.mapped_re = div_round(q - p, den, F, 1'b0);
      else r.mapped_re = div_round(p - q, den, F, 1'b1);
      r.mapped_im = div_round(ma, den, 2*F + 1, as < 0);
      if (pole) begin
        r.factor_re = div_round(ma, den, 2*F, as > 0);
        r.factor_im = div_round(mt, den, 2*F, tneg);
      end else begin
        r.factor_re = clip_word(as > 0, ma);
        r.factor_im = clip_word(!tneg && mt != 0, mt);
      end
    end
    cr = $signed(acc_gain_re);
    ci = $signed(acc_gain_im);
    fr = $signed(r.factor_re);
    fi = $signed(r.factor_im);
    r.gain_re = gain_round(cr * fr - ci * fi);
    r.gain_im = gain_round(cr * fi + ci * fr);
    acc_gain_re = r.gain_re;
    acc_gain_im = r.gain_im;
    r.sat = clip_hit;
    return r;
  endfunction

  task automatic check_field(string name, logic [W-1:0] exp_v, logic [W-1:0] got_v);
    if (exp_v !== got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    root_result_t e;
    if (rst) begin
      start_gain_re <= W'(1) << F;
      start_gain_im <= '0;
      acc_gain_re = '0;
      acc_gain_im = '0;
      expected_roots.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_roots.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected, actual %h %h", $time, m_tdata, m_tuser);
        end else begin
          e = expected_roots.pop_front();
          chk_cnt++;
          if (!e.finite) inf_cnt++;
          if (e.sat) sat_cnt++;
          check_field("mapped_real", e.mapped_re, m_tdata[31:0]);
          check_field("mapped_imag", e.mapped_im, m_tdata[63:32]);
          check_field("mapped_finite", W'(e.finite), W'(m_tuser[0]));
          check_field("factor_real", e.factor_re, m_tdata[95:64]);
          check_field("factor_imag", e.factor_im, m_tdata[127:96]);
          check_field("gain_real", e.gain_re, m_tdata[159:128]);
          check_field("gain_imag", e.gain_im, m_tdata[191:160]);
          check_field("saturated", W'(e.sat), W'(m_tuser[1]));
        end
      end
      if (s_tvalid && s_tready)
        expected_roots.push_back(map_root(s_tdata[31:0], s_tdata[63:32], s_tuser[0],
                                          s_tuser[1]));
      if (cfg_we) begin
        if (cfg_index == brmg_pkg::CFG_GAIN_REAL) start_gain_re <= cfg_data;
        else start_gain_im <= cfg_data;
      end
    end
  end

  initial begin
    err_cnt = 0;
    chk_cnt = 0;
    inf_cnt = 0;
    sat_cnt = 0;
  end

endmodule

// File: test/tb_bilinear_root_map_gain.sv
// testbench top for the bilinear root mapper: stimulus, handshake pressure and verdict
`timescale 1ns / 100ps

module tb_bilinear_root_map_gain;

  localparam int  ONE       = 1 << 16;
  localparam int  MAX_CYCLE = 2000000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [191:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we;
  logic         cfg_index;
  logic [31:0]  cfg_data;
  int           errors, pending, checked, nonfinite_seen, sat_seen;
  int           hold_req;
  bit           quiet;
  int           cycle_cnt;

  bilinear_root_map_gain DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  brmg_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked),
    .nonfinite_seen(nonfinite_seen), .sat_seen(sat_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= MAX_CYCLE) begin
        $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending);
        $display("tb_bilinear_root_map_gain failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int r;
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        m_tready <= 1'b0;
        hold_req--;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        r = $urandom_range(99);
        if (!quiet && r < 15) stall = (r < 2) ? $urandom_range(20, 150) : $urandom_range(1, 3);
      end
    end
  end

  task automatic send_root(logic [31:0] re, logic [31:0] im, bit pole, bit first);
    bit ok;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {im, re};
    s_tuser  <= {first, pole};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    gap = 0;
    if (!quiet && $urandom_range(99) < 15)
      gap = ($urandom_range(99) < 10) ? $urandom_range(30, 300) : $urandom_range(1, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || m_tvalid) @(posedge clk);
  endtask

  task automatic write_gain(logic [31:0] g_re, logic [31:0] g_im);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= brmg_pkg::CFG_GAIN_REAL;
    cfg_data  <= g_re;
    @(posedge clk);
    cfg_index <= brmg_pkg::CFG_GAIN_IMAG;
    cfg_data  <= g_im;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_root;
    int          k;
    logic [31:0] re, im;
    k = $urandom_range(9);
    case (k)
      0, 1, 2, 3: begin
        re = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        im = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      end
      4: begin
        re = $urandom;
        im = $urandom;
      end
      5: begin
        re = 32'($urandom_range(0, 512)) - 32'd256;
        im = 32'($urandom_range(0, 512)) - 32'd256 - 32'(ONE);
      end
      6: begin
        re = '0;
        im = -32'(ONE);
      end
      7: begin
        re = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        im = $urandom_range(1) ? $urandom : ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff);
      end
      default: begin
        re = 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
        im = 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
      end
    endcase
    send_root(re, im, $urandom_range(1), $urandom_range(7) == 0);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = brmg_pkg::CFG_GAIN_REAL;
    cfg_data  = '0;
    hold_req  = 0;
    quiet     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gain never loaded, then the reset gain, minus i and extremes
    send_root(32'd3 << 16, 32'd1 << 15, 1'b0, 1'b0);
    send_root(32'd1 << 16, 32'd2 << 16, 1'b1, 1'b0);
    send_root('0, -32'(ONE), 1'b0, 1'b1);
    send_root('0, -32'(ONE), 1'b1, 1'b0);
    send_root('0, '0, 1'b0, 1'b1);
    send_root('0, '0, 1'b1, 1'b0);
    send_root(32'h8000_0000, '0, 1'b0, 1'b1);
    send_root(32'h7fff_ffff, '0, 1'b1, 1'b0);
    send_root('0, 32'h8000_0000, 1'b0, 1'b1);
    send_root('0, 32'h7fff_ffff, 1'b1, 1'b0);
    send_root(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    send_root(32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0);
    send_root(32'd1, -32'(ONE), 1'b1, 1'b1);
    send_root(-32'd1, -32'(ONE) + 32'd1, 1'b1, 1'b0);
    send_root(32'd1, -32'(ONE), 1'b0, 1'b0);
    send_root(32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
    send_root(32'h5555_5555, 32'haaaa_aaaa, 1'b0, 1'b0);
    send_root(32'haaaa_aaaa, 32'h5555_5555, 1'b1, 1'b0);

    write_gain(32'h7fff_ffff, 32'h8000_0000);
    for (int i = 0; i < 250; i++) send_random_root();

    write_gain('0, '0);
    for (int i = 0; i < 100; i++) send_random_root();

    write_gain($urandom, $urandom);
    quiet = 1'b1;
    hold_req = 3000;
    for (int i = 0; i < 300; i++) send_random_root();
    quiet = 1'b0;

    write_gain(32'(ONE), '0);
    for (int i = 0; i < 350; i++) begin
      if (i == 175) drain();
      send_random_root();
    end

    drain();
    repeat (300) @(posedge clk);
    $display("checked %0d results: %0d with the root at minus i, %0d saturated",
             checked, nonfinite_seen, sat_seen);
    $display("covered four gain settings incl. extremes, long output hold-off and idle pause");
    if (errors == 0) begin
      $display("tb_bilinear_root_map_gain passed");
    end else begin
      $display("tb_bilinear_root_map_gain failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/brmg_pkg.sv
design/brmg_div.sv
design/bilinear_root_map_gain.sv
test/brmg_checker.sv
test/tb_bilinear_root_map_gain.sv
